// ===== rtl/mmrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mmrc_pkg
// Shared types, constants and helpers of the multi-mask RGB convolution core.
// ----------------------------------------------------------------------------
package mmrc_pkg;

  // pixel and coefficient geometry
  localparam int PIX_W       = 8;
  localparam int CHANNELS    = 3;
  localparam int RGB_W       = PIX_W * CHANNELS;
  localparam int KERNEL_SIZE = 3;
  localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
  localparam int COEF_W      = 6;
  localparam int MASK_W      = COEF_W * TAPS;
  localparam int PIX_MAX     = 255;

  // arithmetic widths
  localparam int PROD_W  = PIX_W + 1 + COEF_W;   // unsigned pixel x signed coef
  localparam int PART_W  = PROD_W + 3;           // sum of nine products
  localparam int RESP_W  = PART_W - 1;           // clamped at zero
  localparam int TOTAL_W = RESP_W + 2;           // sum of up to four responses

  // parameter defaults
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_MAX_MASKS = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = MASK_W;
  localparam int MCNT_W     = 3;
  localparam int GEO_W      = 12;

  localparam logic [MCNT_W-1:0] RST_MASK_COUNT = MCNT_W'(1);
  localparam logic [GEO_W-1:0]  RST_WIDTH      = GEO_W'(640);
  localparam logic [GEO_W-1:0]  RST_HEIGHT     = GEO_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASK_COUNT   = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_MASK_ZERO    = 3'd3,
    REG_MASK_ONE     = 3'd4,
    REG_MASK_TWO     = 3'd5,
    REG_MASK_THREE   = 3'd6
  } cfg_reg_e;

  // result queue
  localparam int RES_Q_DEPTH = 8;
  localparam int QCNT_W      = $clog2(RES_Q_DEPTH + 1);
  localparam int QRES_W      = QCNT_W + 1;

  // channel 0 is chan_a
  typedef logic [CHANNELS-1:0][PIX_W-1:0] rgb_t;
  // [row][col], row 0 oldest, col 0 leftmost
  typedef rgb_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] win_t;

  // results one pixel causes
  typedef struct packed {
    logic a_vld;   // first result present
    logic a_filt;  // first result is filtered (else left border zero)
    logic b_vld;   // right border result present
    logic b_fe;    // right border closes the frame
  } ctl_t;

  typedef struct packed {
    rgb_t pix;
    logic row_end;
    logic frame_end;
  } res_t;

  typedef struct packed {
    logic a_vld;
    res_t a;
    logic b_vld;
    res_t b;
  } push_t;

  function automatic logic signed [COEF_W-1:0] coef(input logic [MASK_W-1:0] mask,
                                                    input int k);
    return $signed(mask[COEF_W*k +: COEF_W]);
  endfunction

  function automatic logic [1:0] nres(input ctl_t c);
    return {1'b0, c.a_vld} + {1'b0, c.b_vld};
  endfunction

endpackage

// ===== rtl/mmrc_if.sv =====
// ----------------------------------------------------------------------------
// mmrc_if
// Valid/ready channels: pixel requests in, filtered result requests out.
// ----------------------------------------------------------------------------
interface mmrc_pix_if;
  import mmrc_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] chan_a;
  logic [PIX_W-1:0] chan_b;
  logic [PIX_W-1:0] chan_c;

  modport source (output valid, chan_a, chan_b, chan_c, input ready);
  modport sink   (input valid, chan_a, chan_b, chan_c, output ready);
endinterface

interface mmrc_res_if;
  import mmrc_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] res_a;
  logic [PIX_W-1:0] res_b;
  logic [PIX_W-1:0] res_c;
  logic             row_end;
  logic             frame_end;

  modport source (output valid, res_a, res_b, res_c, row_end, frame_end, input ready);
  modport sink   (input valid, res_a, res_b, res_c, row_end, frame_end, output ready);
endinterface

// ===== rtl/mmrc_ram.sv =====
// ----------------------------------------------------------------------------
// mmrc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mmrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/mmrc_window.sv =====
// ----------------------------------------------------------------------------
// mmrc_window
// Raster position, line buffer and 3x3 window; flags which results to emit.
// ----------------------------------------------------------------------------
module mmrc_window #(
  parameter int MAX_WIDTH = mmrc_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  mmrc_pkg::rgb_t              pix_in,
  input  logic [mmrc_pkg::GEO_W-1:0]  image_width,
  input  logic [mmrc_pkg::GEO_W-1:0]  image_height,
  output mmrc_pkg::win_t              win,
  output mmrc_pkg::ctl_t              ctl
);
  import mmrc_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int GW0 = $clog2(MAX_WIDTH + 1);
  localparam int GW  = (GW0 > GEO_W) ? GW0 : GEO_W;

  logic [CW-1:0]    col_r, col_nxt;
  logic [GEO_W-1:0] row_r, row_nxt;
  logic [GW-1:0]    w_raw, w_eff;
  logic [GEO_W-1:0] h_eff;
  logic             last_col, last_row;
  ctl_t             ctl0;

  logic             s1_vld_r;
  ctl_t             s1_ctl_r;
  rgb_t             s1_pix_r;
  logic [CW-1:0]    s1_addr_r;

  logic [2*RGB_W-1:0] rdata;
  rgb_t               up, mid;
  rgb_t               wc_r [6];

  // geometry clamp
  always_comb begin
    w_raw = GW'(image_width);
    if (w_raw < GW'(3)) begin
      w_eff = GW'(3);
    end else if (w_raw > GW'(MAX_WIDTH)) begin
      w_eff = GW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_eff = (image_height < GEO_W'(3)) ? GEO_W'(3) : image_height;
  end

  assign last_col = (GW'(col_r) + GW'(1)) >= w_eff;
  assign last_row = row_r >= (h_eff - GEO_W'(1));

  always_comb begin
    ctl0.a_vld  = (row_r >= GEO_W'(2)) && (col_r != '0);
    ctl0.a_filt = col_r >= CW'(2);
    ctl0.b_vld  = (row_r >= GEO_W'(2)) && last_col;
    ctl0.b_fe   = last_row;
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + GEO_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
      s1_ctl_r <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_vld_r <= acc;
      s1_ctl_r <= acc ? ctl0 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r  <= pix_in;
      s1_addr_r <= col_r;
    end
  end

  // low half: older row, high half: newer row
  mmrc_ram #(
    .WIDTH(2 * RGB_W),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (s1_vld_r),
    .waddr(s1_addr_r),
    .wdata({s1_pix_r, mid}),
    .re   (acc),
    .raddr(col_r),
    .rdata(rdata)
  );

  assign up  = rdata[RGB_W-1:0];
  assign mid = rdata[2*RGB_W-1:RGB_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        wc_r[i] <= '0;
      end
    end else if (s1_vld_r) begin
      wc_r[0] <= wc_r[1];
      wc_r[1] <= up;
      wc_r[2] <= wc_r[3];
      wc_r[3] <= mid;
      wc_r[4] <= wc_r[5];
      wc_r[5] <= s1_pix_r;
    end
  end

  always_comb begin
    win[0][0] = wc_r[0];
    win[0][1] = wc_r[1];
    win[0][2] = up;
    win[1][0] = wc_r[2];
    win[1][1] = wc_r[3];
    win[1][2] = mid;
    win[2][0] = wc_r[4];
    win[2][1] = wc_r[5];
    win[2][2] = s1_pix_r;
  end

  assign ctl = s1_ctl_r;

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last_col |=> col_r == '0)
    else $error("column counter did not wrap after last column");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> s1_ctl_r == '0)
    else $error("results flagged without an accepted pixel");

endmodule

// ===== rtl/mmrc_mac.sv =====
// ----------------------------------------------------------------------------
// mmrc_mac
// Per-mask products, clamped mask sums, channel totals clamped to 0..255.
// ----------------------------------------------------------------------------
module mmrc_mac #(
  parameter int MAX_MASKS = mmrc_pkg::DEF_MAX_MASKS
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  mmrc_pkg::win_t                              win,
  input  mmrc_pkg::ctl_t                              ctl_in,
  input  logic [MAX_MASKS-1:0][mmrc_pkg::MASK_W-1:0]  masks,
  input  logic [mmrc_pkg::MCNT_W-1:0]                 mask_count,
  output mmrc_pkg::ctl_t                              ctl_p,
  output mmrc_pkg::ctl_t                              ctl_s,
  output mmrc_pkg::push_t                             push
);
  import mmrc_pkg::*;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [RESP_W-1:0]        resp_t;

  prod_t prod_nxt [CHANNELS][MAX_MASKS][TAPS];
  prod_t prod_r   [CHANNELS][MAX_MASKS][TAPS];
  resp_t resp_nxt [CHANNELS][MAX_MASKS];
  resp_t resp_r   [CHANNELS][MAX_MASKS];
  ctl_t  ctl_p_r, ctl_s_r;

  logic [MCNT_W-1:0] n_eff;
  rgb_t              filt;

  // stage 1: 8x6 products, all lanes in parallel
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int m = 0; m < MAX_MASKS; m++) begin
        for (int i = 0; i < KERNEL_SIZE; i++) begin
          for (int j = 0; j < KERNEL_SIZE; j++) begin
            prod_nxt[ch][m][i*KERNEL_SIZE+j] =
              $signed({1'b0, win[i][j][ch]}) * coef(masks[m], i*KERNEL_SIZE + j);
          end
        end
      end
    end
  end

  // stage 2: nine-tap sum, negative responses dropped, idle masks zeroed
  always_comb begin
    logic signed [PART_W-1:0] part;
    if (mask_count == '0) begin
      n_eff = MCNT_W'(1);
    end else if (mask_count > MCNT_W'(MAX_MASKS)) begin
      n_eff = MCNT_W'(MAX_MASKS);
    end else begin
      n_eff = mask_count;
    end
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int m = 0; m < MAX_MASKS; m++) begin
        part = '0;
        for (int k = 0; k < TAPS; k++) begin
          part = part + PART_W'(prod_r[ch][m][k]);
        end
        if ((m < int'(n_eff)) && !part[PART_W-1]) begin
          resp_nxt[ch][m] = part[RESP_W-1:0];
        end else begin
          resp_nxt[ch][m] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    resp_r <= resp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_p_r <= '0;
      ctl_s_r <= '0;
    end else begin
      ctl_p_r <= ctl_in;
      ctl_s_r <= ctl_p_r;
    end
  end

  // stage 3: add mask responses, saturate
  always_comb begin
    logic [TOTAL_W-1:0] tot;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      tot = '0;
      for (int m = 0; m < MAX_MASKS; m++) begin
        tot = tot + TOTAL_W'(resp_r[ch][m]);
      end
      filt[ch] = (tot > TOTAL_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : tot[PIX_W-1:0];
    end
  end

  always_comb begin
    push.a_vld       = ctl_s_r.a_vld;
    push.a.pix       = ctl_s_r.a_filt ? filt : '0;
    push.a.row_end   = 1'b0;
    push.a.frame_end = 1'b0;
    push.b_vld       = ctl_s_r.b_vld;
    push.b.pix       = '0;
    push.b.row_end   = 1'b1;
    push.b.frame_end = ctl_s_r.b_fe;
  end

  assign ctl_p = ctl_p_r;
  assign ctl_s = ctl_s_r;

  a_border_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_s_r.b_vld |-> ctl_s_r.a_vld)
    else $error("right border without the pixel before it");

endmodule

// ===== rtl/mmrc_fifo.sv =====
// ----------------------------------------------------------------------------
// mmrc_fifo
// Result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module mmrc_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mmrc_pkg::push_t             push,
  input  logic                        pop,
  output logic                        valid,
  output mmrc_pkg::res_t              head,
  output logic [mmrc_pkg::QCNT_W-1:0] count
);
  import mmrc_pkg::*;

  localparam int AW = $clog2(RES_Q_DEPTH);

  res_t              q_r [RES_Q_DEPTH];
  logic [AW-1:0]     wr_r, rd_r, wr_b;
  logic [QCNT_W-1:0] cnt_r;
  logic [QRES_W-1:0] cnt_sum;

  assign wr_b    = push.a_vld ? wr_r + AW'(1) : wr_r;
  assign cnt_sum = QRES_W'(cnt_r) + QRES_W'(push.a_vld) + QRES_W'(push.b_vld);

  always_ff @(posedge clk) begin
    if (push.a_vld) begin
      q_r[wr_r] <= push.a;
    end
    if (push.b_vld) begin
      q_r[wr_b] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + AW'(push.a_vld) + AW'(push.b_vld);
      rd_r  <= rd_r + AW'(pop);
      cnt_r <= QCNT_W'(cnt_sum - QRES_W'(pop));
    end
  end

  assign valid = cnt_r != '0;
  assign head  = q_r[rd_r];
  assign count = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_sum - QRES_W'(pop) <= QRES_W'(RES_Q_DEPTH))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("result queue popped while empty");

endmodule

// ===== rtl/multi_mask_rgb_convolution_core.sv =====
// ----------------------------------------------------------------------------
// multi_mask_rgb_convolution_core
// Streaming 3x3 multi-mask RGB filter with line buffer and result queue.
// ----------------------------------------------------------------------------
// Throughput: one pixel request per cycle while in ready is high. Each row's last pixel
//   yields two results and its first none, so from row 2 on the output side sees one result per pixel on average.
// Pipeline: line buffer read at the accept edge, then products, mask sums and totals
//   into the 8-entry result queue.
// in ready drops only when the queue cannot reserve room for a pixel's results.
// Reset (rst_n, sync): registers back to defaults, position and window cleared;
//   line buffer contents are left as they are.
// ----------------------------------------------------------------------------
module multi_mask_rgb_convolution_core #(
  parameter int MAX_WIDTH = mmrc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_MASKS = mmrc_pkg::DEF_MAX_MASKS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mmrc_pix_if.sink                         in_pix,
  mmrc_res_if.source                       out_res,
  input  logic                             cfg_we,
  input  logic [mmrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mmrc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mmrc_pkg::*;

  // configuration registers
  logic [MCNT_W-1:0]                mask_count_r;
  logic [GEO_W-1:0]                 width_r;
  logic [GEO_W-1:0]                 height_r;
  logic [MAX_MASKS-1:0][MASK_W-1:0] masks_r;

  logic              acc;
  rgb_t              pix;
  win_t              win;
  ctl_t              ctl_w, ctl_p, ctl_s;
  push_t             push;
  logic              q_valid;
  res_t              q_head;
  logic [QCNT_W-1:0] q_count;
  logic [QRES_W-1:0] reserved;

  // ---- configuration writes (user writes only while idle; the block does not enforce it) ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_count_r <= RST_MASK_COUNT;
      width_r      <= RST_WIDTH;
      height_r     <= RST_HEIGHT;
      masks_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        REG_MASK_COUNT:   mask_count_r <= cfg_wdata[MCNT_W-1:0];
        REG_IMAGE_WIDTH:  width_r      <= cfg_wdata[GEO_W-1:0];
        REG_IMAGE_HEIGHT: height_r     <= cfg_wdata[GEO_W-1:0];
        REG_MASK_ZERO, REG_MASK_ONE, REG_MASK_TWO, REG_MASK_THREE: begin
          // masks above MAX_MASKS are never used, so not stored
          for (int k = 0; k < MAX_MASKS; k++) begin
            if (cfg_index == CFG_IDX_W'(int'(REG_MASK_ZERO) + k)) begin
              masks_r[k] <= cfg_wdata[MASK_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---- input side ----
  // Reserve queue room for every result still in the pipe plus two more.
  assign reserved = QRES_W'(q_count) + QRES_W'(nres(ctl_w)) + QRES_W'(nres(ctl_p))
                  + QRES_W'(nres(ctl_s));
  assign in_pix.ready = reserved <= QRES_W'(RES_Q_DEPTH - 2);
  assign acc          = in_pix.valid && in_pix.ready;

  assign pix[0] = in_pix.chan_a;
  assign pix[1] = in_pix.chan_b;
  assign pix[2] = in_pix.chan_c;

  // position, line buffer, window
  mmrc_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .pix_in      (pix),
    .image_width (width_r),
    .image_height(height_r),
    .win         (win),
    .ctl         (ctl_w)
  );

  // filter arithmetic
  mmrc_mac #(
    .MAX_MASKS(MAX_MASKS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .win       (win),
    .ctl_in    (ctl_w),
    .masks     (masks_r),
    .mask_count(mask_count_r),
    .ctl_p     (ctl_p),
    .ctl_s     (ctl_s),
    .push      (push)
  );

  // ---- output side: queue decouples result backpressure ----
  mmrc_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (out_res.valid && out_res.ready),
    .valid(q_valid),
    .head (q_head),
    .count(q_count)
  );

  assign out_res.valid     = q_valid;
  assign out_res.res_a     = q_head.pix[0];
  assign out_res.res_b     = q_head.pix[1];
  assign out_res.res_c     = q_head.pix[2];
  assign out_res.row_end   = q_head.row_end;
  assign out_res.frame_end = q_head.frame_end;

  a_frame_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.frame_end |-> out_res.row_end)
    else $error("frame end outside a row end");

endmodule

// ===== sim/tb_multi_mask_rgb_convolution_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_mask_rgb_convolution_core
// Self-checking bench for the 3x3 multi-mask RGB filter. Pixel requests are fed
// in raster order from a pending queue and each accepted pixel runs through a
// behavioral filter that keeps its own line rows, window and registers. The
// results it predicts are compared field by field with the result requests
// that the core delivers, under phases of source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_multi_mask_rgb_convolution_core;
  import mmrc_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int RAND_PIXELS = 800;      // random pixel budget
  localparam int LONG_WIDTH  = 300;      // long-line frame width
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // no register here

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_e;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mmrc_pix_if pix_ch ();
  mmrc_res_if res_ch ();

  multi_mask_rgb_convolution_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // --------------------------------------------------------------------------
  // Filter state as the core should hold it. Registers start at reset values.
  // --------------------------------------------------------------------------
  logic [MCNT_W-1:0] n_masks_reg = RST_MASK_COUNT;
  logic [GEO_W-1:0]  width_reg   = RST_WIDTH;
  logic [GEO_W-1:0]  height_reg  = RST_HEIGHT;
  logic [MASK_W-1:0] mask_reg [4] = '{default: '0};

  rgb_t        older_row [DEF_MAX_WIDTH];   // image row two above the current
  rgb_t        prev_row  [DEF_MAX_WIDTH];   // image row just above
  rgb_t        nbr_cols  [6] = '{default: '0};  // two left columns, 3 rows
  logic [10:0] next_col = '0;
  logic [11:0] next_row = '0;

  res_t  exp_pixels [$];   // filtered and border results still owed by the core
  rgb_t  pix_pending [$];  // pixel requests not yet presented
  int    pix_owed;         // queued or presented but not yet accepted
  int    err_count;
  idle_e idle_mode;
  int unsigned cycles;
  rgb_t  nxt_pix;
  res_t  want;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Sink rolls each cycle, the source when free; IDLE_BOTH: lighter rate on both.
  function automatic bit skip_cycle(input bit sink_side);
    case (idle_mode)
      IDLE_SRC:  return !sink_side && ($urandom_range(0, 99) < 61);
      IDLE_SNK:  return sink_side && ($urandom_range(0, 99) < 61);
      IDLE_BOTH: return $urandom_range(0, 99) < 33;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic void push_expect(input rgb_t px, input bit re, input bit fe);
    res_t r;
    r.pix       = px;
    r.row_end   = re;
    r.frame_end = fe;
    exp_pixels.push_back(r);
  endfunction

  // Weighted sums per channel: each mask clamped at zero, total clamped at 255.
  function automatic rgb_t conv_window(input rgb_t up, input rgb_t mid, input rgb_t cur);
    rgb_t nb [KERNEL_SIZE][KERNEL_SIZE];
    rgb_t px;
    int   active, total, part, wt;
    active = (n_masks_reg < 1) ? 1 :
             ((n_masks_reg > DEF_MAX_MASKS) ? DEF_MAX_MASKS : int'(n_masks_reg));
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      nb[i][0] = nbr_cols[2*i];
      nb[i][1] = nbr_cols[2*i+1];
    end
    nb[0][2] = up;
    nb[1][2] = mid;
    nb[2][2] = cur;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      total = 0;
      for (int m = 0; m < active; m++) begin
        part = 0;
        for (int k = 0; k < TAPS; k++) begin
          wt = int'(mask_reg[m][COEF_W*k +: COEF_W]);
          if (wt >= 32) wt -= 64;
          part += int'(nb[k / KERNEL_SIZE][k % KERNEL_SIZE][ch]) * wt;
        end
        if (part < 0) part = 0;
        total += part;
      end
      if (total > PIX_MAX) total = PIX_MAX;
      px[ch] = 8'(total);
    end
    return px;
  endfunction

  // Advance the filter by one accepted pixel and log the results it causes.
  task automatic edge_predict(input rgb_t cur);
    int unsigned w, h;
    logic [10:0] c;
    logic [11:0] r;
    rgb_t        up, mid;
    bit          last_col, last_row;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    h = height_reg;
    if (h < 3) h = 3;
    c = next_col;
    r = next_row;
    // a position beyond shrunk geometry counts as the last column / row
    last_col = (c >= w - 1);
    last_row = (r >= h - 1);
    up  = older_row[c];
    mid = prev_row[c];
    if (r >= 2) begin
      if (c == 1) begin
        push_expect('0, 1'b0, 1'b0);           // left border column
      end else if (c >= 2) begin
        push_expect(conv_window(up, mid, cur), 1'b0, 1'b0);
      end
      if (last_col) push_expect('0, 1'b1, last_row);  // right border closes row
    end
    nbr_cols[0] = nbr_cols[1];
    nbr_cols[1] = up;
    nbr_cols[2] = nbr_cols[3];
    nbr_cols[3] = mid;
    nbr_cols[4] = nbr_cols[5];
    nbr_cols[5] = cur;
    older_row[c] = mid;
    prev_row[c]  = cur;
    if (last_col) begin
      next_col = '0;
      next_row = last_row ? '0 : r + 1'b1;
    end else begin
      next_col = c + 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents pending pixel requests, predicts on every accept.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        edge_predict({pix_ch.chan_c, pix_ch.chan_b, pix_ch.chan_a});
        pix_owed--;
      end
      if (!pix_ch.valid || pix_ch.ready) begin
        if (pix_pending.size() != 0 && !skip_cycle(1'b0)) begin
          nxt_pix = pix_pending.pop_front();
          pix_ch.valid  <= 1'b1;
          pix_ch.chan_a <= nxt_pix[0];
          pix_ch.chan_b <= nxt_pix[1];
          pix_ch.chan_c <= nxt_pix[2];
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result request against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (exp_pixels.size() == 0) begin
          flag_error($sformatf("unexpected result %h %h %h re=%b fe=%b",
                               res_ch.res_a, res_ch.res_b, res_ch.res_c,
                               res_ch.row_end, res_ch.frame_end));
        end else begin
          want = exp_pixels.pop_front();
          if (res_ch.res_a !== want.pix[0])
            flag_error($sformatf("res_a %h, want %h", res_ch.res_a, want.pix[0]));
          if (res_ch.res_b !== want.pix[1])
            flag_error($sformatf("res_b %h, want %h", res_ch.res_b, want.pix[1]));
          if (res_ch.res_c !== want.pix[2])
            flag_error($sformatf("res_c %h, want %h", res_ch.res_c, want.pix[2]));
          if (res_ch.row_end !== want.row_end)
            flag_error($sformatf("row_end %b, want %b", res_ch.row_end, want.row_end));
          if (res_ch.frame_end !== want.frame_end)
            flag_error($sformatf("frame_end %b, want %b", res_ch.frame_end,
                                 want.frame_end));
        end
      end
      res_ch.ready <= !skip_cycle(1'b1);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Call at a clock edge; the write lands at the next edge.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_MASK_COUNT:   n_masks_reg = data[MCNT_W-1:0];
      REG_IMAGE_WIDTH:  width_reg   = data[GEO_W-1:0];
      REG_IMAGE_HEIGHT: height_reg  = data[GEO_W-1:0];
      REG_MASK_ZERO:    mask_reg[0] = data;
      REG_MASK_ONE:     mask_reg[1] = data;
      REG_MASK_TWO:     mask_reg[2] = data;
      REG_MASK_THREE:   mask_reg[3] = data;
      default: ;        // unmapped index, dropped
    endcase
    @(posedge clk);
  endtask

  // Random garbage above the register's width; the core must drop it.
  function automatic logic [CFG_DATA_W-1:0] junk_above(input int v, input int bits);
    logic [CFG_DATA_W-1:0] r;
    r = {$urandom, $urandom};
    return (r << bits) | CFG_DATA_W'(v);
  endfunction

  task automatic setup(input int mc, input int w, input int h,
                       input logic [MASK_W-1:0] m0, input logic [MASK_W-1:0] m1,
                       input logic [MASK_W-1:0] m2, input logic [MASK_W-1:0] m3);
    cfg_write(REG_MASK_COUNT, junk_above(mc, MCNT_W));
    cfg_write(REG_IMAGE_WIDTH, junk_above(w, GEO_W));
    cfg_write(REG_IMAGE_HEIGHT, junk_above(h, GEO_W));
    cfg_write(REG_MASK_ZERO, m0);
    cfg_write(REG_MASK_ONE, m1);
    cfg_write(REG_MASK_TWO, m2);
    cfg_write(REG_MASK_THREE, m3);
    cfg_we <= 1'b0;
  endtask

  // span 0: any coefficient; otherwise each weight in -span..span
  function automatic logic [MASK_W-1:0] pick_mask(input int span);
    logic [MASK_W-1:0] m;
    int wt;
    m = MASK_W'({$urandom, $urandom});
    if (span > 0) begin
      for (int k = 0; k < TAPS; k++) begin
        wt = $urandom_range(0, 2 * span) - span;
        m[COEF_W*k +: COEF_W] = wt[COEF_W-1:0];
      end
    end
    return m;
  endfunction

  // style 0 full range, 1 dim, 2 near the rails; a tenth of pixels are noise
  function automatic rgb_t pick_pixel(input int style);
    rgb_t px;
    px = $urandom_range(0, 24'hFF_FFFF);
    if ($urandom_range(0, 9) == 0) return px;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      case (style)
        1:       px[ch] = $urandom_range(0, 15);
        2:       px[ch] = ($urandom_range(0, 1) ? 8'hFE : 8'h00) | 8'($urandom_range(0, 1));
        default: ;
      endcase
    end
    return px;
  endfunction

  task automatic send_pixel(input rgb_t px);
    pix_pending.push_back(px);
    pix_owed++;
  endtask

  task automatic queue_pixels(input int count, input int style);
    for (int i = 0; i < count; i++) send_pixel(pick_pixel(style));
  endtask

  // Source holds off until every request is in and every result is out, then
  // lets the pipeline drain (rows 0/1 give no results to wait on).
  task automatic wait_idle();
    while (pix_owed != 0 || exp_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stim
    int   phase, rand_pixels, w_raw, h_raw, w_eff, h_eff, span;
    rgb_t px;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    pix_ch.valid  = 1'b0;
    pix_ch.chan_a = '0;
    pix_ch.chan_b = '0;
    pix_ch.chan_c = '0;
    res_ch.ready  = 1'b0;
    pix_owed      = 0;
    err_count     = 0;
    idle_mode     = IDLE_NONE;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest frame, out-of-range count/width/height (act as 1, 3, 3), weights
    // at both coefficient rails, checkerboard of 0/255 with an inverted second
    // channel so both clamps fire. The unmapped index is written and dropped.
    cfg_write(REG_UNUSED, {$urandom, $urandom});
    setup(0, 2, 1, {3{6'h1F, 6'h20, 6'h1F}}, pick_mask(0), pick_mask(0), pick_mask(0));
    for (int i = 0; i < 9; i++) begin
      px[0] = (i % 2 == 0) ? 8'hFF : 8'h00;
      px[1] = ~px[0];
      px[2] = 8'(i * 31);
      send_pixel(px);
    end
    wait_idle();

    // Count above the mask limit (acts as 4): sobel x, sobel y, all -32, center 31
    setup(7, 3, 3,
          {6'h01, 6'h00, 6'h3F, 6'h02, 6'h00, 6'h3E, 6'h01, 6'h00, 6'h3F},
          {6'h01, 6'h02, 6'h01, 6'h00, 6'h00, 6'h00, 6'h3F, 6'h3E, 6'h3F},
          {9{6'h20}},
          {24'h0, 6'h1F, 24'h0});
    queue_pixels(9, 0);
    wait_idle();

    // Long line, height 0 acts as 3
    idle_mode = IDLE_BOTH;
    setup(2, LONG_WIDTH, 0, pick_mask(2), pick_mask(8), pick_mask(0), pick_mask(0));
    queue_pixels(LONG_WIDTH * 3, 0);
    wait_idle();

    // Geometry shrunk mid-frame: column 7 becomes past the last column, then
    // row 4 becomes past the last row and the frame closes after it.
    idle_mode = IDLE_SNK;
    setup(3, 10, 5, pick_mask(2), pick_mask(2), pick_mask(8), pick_mask(0));
    queue_pixels(2 * 10 + 7, 0);
    wait_idle();
    cfg_write(REG_IMAGE_WIDTH, junk_above(5, GEO_W));
    cfg_we <= 1'b0;
    queue_pixels(1 + 5, 1);
    wait_idle();
    cfg_write(REG_IMAGE_HEIGHT, junk_above(3, GEO_W));
    cfg_we <= 1'b0;
    queue_pixels(5, 2);
    wait_idle();

    // Random whole frames; each phase rewrites every register before its frames
    // and rotates the idle pattern.
    phase       = 0;
    rand_pixels = 0;
    while (rand_pixels < RAND_PIXELS) begin
      idle_mode = idle_e'(phase % 4);
      case ($urandom_range(0, 9))
        0:       w_raw = $urandom_range(0, 2);
        1:       w_raw = $urandom_range(17, 80);
        default: w_raw = $urandom_range(3, 16);
      endcase
      h_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      w_eff = (w_raw < 3) ? 3 : w_raw;
      h_eff = (h_raw < 3) ? 3 : h_raw;
      case ($urandom_range(0, 2))
        0:       span = 0;
        1:       span = 2;
        default: span = 8;
      endcase
      setup($urandom_range(0, 7), w_raw, h_raw,
            pick_mask(span), pick_mask(span), pick_mask(span), pick_mask(span));
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        queue_pixels(w_eff * h_eff, $urandom_range(0, 2));
        rand_pixels += w_eff * h_eff;
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    repeat (2 * SETTLE) @(posedge clk);
    if (exp_pixels.size() != 0)
      flag_error($sformatf("%0d results never arrived", exp_pixels.size()));

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
